// ===== sv/fpa_pkg.sv =====
// shared types and constants for the fixed-point alu
package fpa_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_GE       = 4'd5,
		OP_LT       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} fpa_op_t;

	typedef struct packed {
		logic [3:0]               action;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} fpa_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     compare_true;
		logic                     divide_by_zero;
	} fpa_rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              compare_true;
		logic              divide_by_zero;
		logic              is_div;
		logic              quot_neg;
	} fpa_side_t;

endpackage

// ===== sv/fpa_divider.sv =====
// pipelined restoring divider on magnitudes, carries request side info alongside
module fpa_divider #(
	parameter int DVD_W          = 40,
	parameter int BITS_PER_STAGE = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  fpa_pkg::fpa_side_t            in_side,
	input  logic [DVD_W-1:0]              dividend,
	input  logic [fpa_pkg::DATA_W-1:0]    divisor,
	output logic                          out_valid,
	output fpa_pkg::fpa_side_t            out_side,
	output logic [fpa_pkg::DATA_W-1:0]    quotient
);

	localparam int W      = fpa_pkg::DATA_W;
	localparam int STAGES = (DVD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int PAD_W  = STAGES * BITS_PER_STAGE;

	typedef struct packed {
		logic [PAD_W-1:0] dvd;
		logic [W-1:0]     rem;
		logic [W-1:0]     quo;
	} dstate_t;

	function automatic dstate_t div_step(dstate_t cur, logic [W-1:0] dsr);
		dstate_t    nxt;
		logic [W:0] trial;
		nxt = cur;
		for (int k = 0; k < BITS_PER_STAGE; k++) begin
			trial   = {nxt.rem, nxt.dvd[PAD_W-1]};
			nxt.dvd = {nxt.dvd[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr}) begin
				nxt.rem = W'(trial - {1'b0, dsr});
				nxt.quo = {nxt.quo[W-2:0], 1'b1};
			end else begin
				nxt.rem = trial[W-1:0];
				nxt.quo = {nxt.quo[W-2:0], 1'b0};
			end
		end
		return nxt;
	endfunction

	logic               vld_s  [STAGES];
	fpa_pkg::fpa_side_t side_s [STAGES];
	dstate_t            st_s   [STAGES];
	logic [W-1:0]       dsr_s  [STAGES];
	dstate_t            st_nx  [STAGES];
	dstate_t            st_in;

	always_comb begin
		st_in.dvd = PAD_W'(dividend);
		st_in.rem = '0;
		st_in.quo = '0;
		st_nx[0] = div_step(st_in, divisor);
		for (int i = 1; i < STAGES; i++) begin
			st_nx[i] = div_step(st_s[i-1], dsr_s[i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		dsr_s[0]  <= divisor;
		st_s[0]   <= st_nx[0];
		for (int i = 1; i < STAGES; i++) begin
			side_s[i] <= side_s[i-1];
			dsr_s[i]  <= dsr_s[i-1];
			st_s[i]   <= st_nx[i];
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];
	assign quotient  = st_s[STAGES-1].quo;

endmodule

// ===== sv/fixed_point_alu_core.sv =====
// top level of the fixed-point alu: operand stage, multiply stage, divider pipeline, output
// done follows the request register, setup register, divider stages and output register
// throughput: one request per cycle, busy stays low, every operation takes the same path
// the divider resolves four quotient bits per stage and sets the depth
// reset: arst_n clears all valid bits and done, no request in flight survives it
// results cannot be stalled, done is a single-cycle strobe
module fixed_point_alu_core #(
	parameter int FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fpa_pkg::fpa_req_t request,
	output logic              done,
	output fpa_pkg::fpa_rsp_t result
);

	localparam int W     = fpa_pkg::DATA_W;
	localparam int DVD_W = W + FRAC_BITS;

	logic               vld_s1;
	fpa_pkg::fpa_req_t  req_s1;

	logic               vld_s2;
	logic               mul_s2;
	fpa_pkg::fpa_side_t side_s2;
	logic signed [2*W-1:0] prod_s2;
	logic [DVD_W-1:0]   dvd_s2;
	logic [W-1:0]       dsr_s2;

	logic signed [W-1:0] a;
	logic signed [W-1:0] b;
	logic [W-1:0]       mag_a;
	logic [W-1:0]       mag_b;
	fpa_pkg::fpa_side_t side_c;

	logic signed [2*W-1:0] prod_sh;
	fpa_pkg::fpa_side_t div_side_in;

	logic               div_valid;
	fpa_pkg::fpa_side_t div_side;
	logic [W-1:0]       div_quo;
	logic [W-1:0]       quo_signed;
	fpa_pkg::fpa_rsp_t  rsp_c;

	logic               done_q;
	fpa_pkg::fpa_rsp_t  result_q;

	assign busy = 1'b0;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	// simple operations, operand magnitudes
	assign a     = req_s1.operand_a;
	assign b     = req_s1.operand_b;
	assign mag_a = a[W-1] ? (~a + 1'b1) : a;
	assign mag_b = b[W-1] ? (~b + 1'b1) : b;

	always_comb begin
		side_c = '0;
		unique case (fpa_pkg::fpa_op_t'(req_s1.action))
			fpa_pkg::OP_ADD:      side_c.value = a + b;
			fpa_pkg::OP_SUB:      side_c.value = a - b;
			fpa_pkg::OP_MUL:      side_c.value = '0;
			fpa_pkg::OP_DIV: begin
				side_c.is_div         = 1'b1;
				side_c.divide_by_zero = (b == '0);
				side_c.quot_neg       = a[W-1] ^ b[W-1];
			end
			fpa_pkg::OP_GT:       side_c.compare_true = (a > b);
			fpa_pkg::OP_GE:       side_c.compare_true = (a >= b);
			fpa_pkg::OP_LT:       side_c.compare_true = (a < b);
			fpa_pkg::OP_LE:       side_c.compare_true = (a <= b);
			fpa_pkg::OP_EQ:       side_c.compare_true = (a == b);
			fpa_pkg::OP_NE:       side_c.compare_true = (a != b);
			fpa_pkg::OP_MIN:      side_c.value = (a <= b) ? a : b;
			fpa_pkg::OP_MAX:      side_c.value = (a >= b) ? a : b;
			fpa_pkg::OP_INC:      side_c.value = a + 1'b1;
			fpa_pkg::OP_DEC:      side_c.value = a - 1'b1;
			fpa_pkg::OP_FROM_INT: side_c.value = a << FRAC_BITS;
			fpa_pkg::OP_TO_INT:   side_c.value = a >>> FRAC_BITS;
		endcase
	end

	// multiply and divider setup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2  <= (req_s1.action == fpa_pkg::OP_MUL);
		side_s2 <= side_c;
		prod_s2 <= (2*W)'(a) * (2*W)'(b);
		dvd_s2  <= {mag_a, {FRAC_BITS{1'b0}}};
		dsr_s2  <= mag_b;
	end

	assign prod_sh = prod_s2 >>> FRAC_BITS;

	always_comb begin
		div_side_in = side_s2;
		if (mul_s2) begin
			div_side_in.value = prod_sh[W-1:0];
		end
	end

	fpa_divider #(
		.DVD_W          (DVD_W),
		.BITS_PER_STAGE (4)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_side   (div_side_in),
		.dividend  (dvd_s2),
		.divisor   (dsr_s2),
		.out_valid (div_valid),
		.out_side  (div_side),
		.quotient  (div_quo)
	);

	// sign fixup and result select
	assign quo_signed = div_side.quot_neg ? (~div_quo + 1'b1) : div_quo;

	always_comb begin
		rsp_c.compare_true   = div_side.compare_true;
		rsp_c.divide_by_zero = div_side.divide_by_zero;
		if (div_side.is_div) begin
			rsp_c.value = div_side.divide_by_zero ? '0 : quo_signed;
		end else begin
			rsp_c.value = div_side.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= rsp_c;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== dv/fixed_point_alu_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for fixed_point_alu_core: directed corner cases, then random requests
module fixed_point_alu_core_tb;
	import fpa_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [31:0] RAW_MIN = 32'h8000_0000;
	localparam logic [31:0] RAW_MAX = 32'h7fff_ffff;
	localparam logic [31:0] RAW_NEG_ONE = 32'hffff_ffff;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	fpa_req_t request;
	logic done;
	fpa_rsp_t result;

	fpa_rsp_t expected_results[$];
	int mismatch_count;
	int stall_cycles;
	int sender_idle_pct;

	fixed_point_alu_core #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic fpa_rsp_t fpa_predict(fpa_req_t req);
		longint a;
		longint b;
		longint scale;
		longint full;
		fpa_rsp_t rsp;
		a = longint'($signed(req.operand_a));
		b = longint'($signed(req.operand_b));
		scale = longint'(1) <<< FRAC_BITS;
		full = 0;
		rsp = '0;
		case (fpa_op_t'(req.action))
			OP_ADD: full = a + b;
			OP_SUB: full = a - b;
			OP_MUL: full = (a * b) >>> FRAC_BITS;
			OP_DIV: begin
				if (b == 0)
					rsp.divide_by_zero = 1'b1;
				else
					full = (a * scale) / b;
			end
			OP_GT: rsp.compare_true = a > b;
			OP_GE: rsp.compare_true = a >= b;
			OP_LT: rsp.compare_true = a < b;
			OP_LE: rsp.compare_true = a <= b;
			OP_EQ: rsp.compare_true = a == b;
			OP_NE: rsp.compare_true = a != b;
			OP_MIN: full = (a <= b) ? a : b;
			OP_MAX: full = (a >= b) ? a : b;
			OP_INC: full = a + 1;
			OP_DEC: full = a - 1;
			OP_FROM_INT: full = a * scale;
			default: full = a >>> FRAC_BITS;
		endcase
		rsp.value = full[31:0];
		return rsp;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	// results are checked in order, requests are predicted as they are accepted
	always @(posedge clk) begin : result_monitor
		fpa_rsp_t want;
		bit progressed;
		if (arst_n) begin
			progressed = 1'b0;
			if (done) begin
				progressed = 1'b1;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result value", result.value, '0);
				end else begin
					want = expected_results.pop_front();
					if (result.value !== want.value)
						report_mismatch("value", result.value, want.value);
					if (result.compare_true !== want.compare_true)
						report_mismatch("compare_true", 32'(result.compare_true),
							32'(want.compare_true));
					if (result.divide_by_zero !== want.divide_by_zero)
						report_mismatch("divide_by_zero", 32'(result.divide_by_zero),
							32'(want.divide_by_zero));
				end
			end
			if (start && !busy) begin
				progressed = 1'b1;
				expected_results.push_back(fpa_predict(request));
			end
			if (progressed)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic send_request(input fpa_op_t op, input logic [31:0] a, input logic [31:0] b);
		@(negedge clk);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			request <= $bits(fpa_req_t)'({$urandom, $urandom, $urandom});
			@(negedge clk);
		end
		start <= 1'b1;
		request.action <= op;
		request.operand_a <= a;
		request.operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return RAW_MIN;
			1: return RAW_MAX;
			2: return '0;
			3: return $urandom_range(1) ? 32'd1 : RAW_NEG_ONE;
			4, 5: return 32'($urandom_range(2047)) - 32'd1024;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_arith_extremes();
		send_request(OP_ADD, RAW_MAX, 32'd1);
		send_request(OP_SUB, RAW_MIN, 32'd1);
		send_request(OP_MUL, RAW_MAX, RAW_MAX);
		send_request(OP_MUL, RAW_MIN, RAW_MIN);
		send_request(OP_MUL, RAW_NEG_ONE, 32'd1);
	endtask

	task automatic test_divide_cases();
		send_request(OP_DIV, 32'd1234, '0);
		send_request(OP_DIV, RAW_MIN, RAW_NEG_ONE);
		send_request(OP_DIV, RAW_MAX, 32'd1);
		send_request(OP_DIV, 32'hffff_fffd, 32'd2);
		send_request(OP_DIV, 32'd768, 32'hffff_fe00);
	endtask

	task automatic test_compare_select();
		send_request(OP_GT, RAW_MIN, RAW_MAX);
		send_request(OP_GE, 32'd77, 32'd77);
		send_request(OP_LT, RAW_MIN, RAW_MAX);
		send_request(OP_LE, RAW_MAX, RAW_MIN);
		send_request(OP_EQ, RAW_NEG_ONE, RAW_NEG_ONE);
		send_request(OP_NE, '0, RAW_MIN);
		send_request(OP_MIN, RAW_NEG_ONE, 32'd1);
		send_request(OP_MAX, RAW_NEG_ONE, 32'd1);
	endtask

	task automatic test_unary_ops();
		send_request(OP_INC, RAW_MAX, RAW_MIN);
		send_request(OP_DEC, RAW_MIN, RAW_MAX);
		send_request(OP_FROM_INT, 32'h0080_0000, RAW_NEG_ONE);
		send_request(OP_FROM_INT, RAW_NEG_ONE, '0);
		send_request(OP_TO_INT, RAW_NEG_ONE, RAW_MAX);
		send_request(OP_TO_INT, RAW_MIN, '0);
	endtask

	task automatic test_random_mix(input int count, input int idle_pct);
		fpa_op_t op;
		logic [31:0] a;
		logic [31:0] b;
		sender_idle_pct = idle_pct;
		repeat (count) begin
			op = fpa_op_t'($urandom_range(15));
			a = pick_operand();
			case ($urandom_range(7))
				0: b = a;
				1: b = (op == OP_DIV) ? '0 : pick_operand();
				default: b = pick_operand();
			endcase
			send_request(op, a, b);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		mismatch_count = 0;
		stall_cycles = 0;
		sender_idle_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_arith_extremes();
		test_divide_cases();
		sender_idle_pct = 61;
		test_compare_select();
		test_unary_ops();
		test_random_mix(500, 0);
		test_random_mix(500, 61);
		test_random_mix(500, 0);
		test_random_mix(500, 23);

		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
